@@ rtl/bmpc_pkg.sv @@
// Package: shared types, constants and codes of the BMP crop stream.
package bmpc_pkg;

  // Default bounds on the source image size
  localparam int unsigned MaxWidthDef  = 4096;
  localparam int unsigned MaxHeightDef = 4096;

  // Field widths
  localparam int unsigned RegW    = 13;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PadW    = 2;
  localparam int unsigned RegIdxW = 3;

  // Configuration register indexes
  typedef enum logic [RegIdxW-1:0] {
    REG_SRC_WIDTH   = 3'd0,
    REG_SRC_HEIGHT  = 3'd1,
    REG_CROP_LEFT   = 3'd2,
    REG_CROP_TOP    = 3'd3,
    REG_CROP_WIDTH  = 3'd4,
    REG_CROP_HEIGHT = 3'd5
  } reg_idx_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK         = 2'd0,
    ST_HEIGHT_ERR = 2'd1,
    ST_WIDTH_ERR  = 2'd2
  } status_e;

  // Configuration register file contents
  typedef struct packed {
    logic [RegW-1:0] src_width;
    logic [RegW-1:0] src_height;
    logic [RegW-1:0] crop_left;
    logic [RegW-1:0] crop_top;
    logic [RegW-1:0] crop_width;
    logic [RegW-1:0] crop_height;
  } cfg_t;

  // Per-item work description, produced at input acceptance
  typedef struct packed {
    logic [ByteW-1:0] data;      // kept byte, zero on error
    status_e          status;
    logic [PadW-1:0]  pad;       // zero bytes to append after data
    logic             last_row;  // item lies in the last cropped row
    logic             img_last;  // data itself is the final image byte
  } desc_t;

endpackage

@@ rtl/bmpc_in_if.sv @@
// Interface: input byte channel of the BMP crop stream.
interface bmpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;

  modport source (output valid, output pixel_byte, input ready);
  modport sink (input valid, input pixel_byte, output ready);
endinterface

@@ rtl/bmpc_out_if.sv @@
// Interface: result byte channel of the BMP crop stream.
interface bmpc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       end_of_run;
  logic       last_of_image;

  modport source (output valid, output out_byte, output status, output end_of_run,
                  output last_of_image, input ready);
  modport sink (input valid, input out_byte, input status, input end_of_run,
                input last_of_image, output ready);
endinterface

@@ rtl/bmpc_track.sv @@
// Module: source position counters and crop window decision per byte.
module bmpc_track
  import bmpc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic [ByteW-1:0] pixel_byte_i,
  input  cfg_t             cfg_i,
  output logic             keep_o,
  output desc_t            desc_o
);

  localparam int unsigned ColW  = $clog2(3 * MAX_WIDTH + 4);
  localparam int unsigned RowW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned CalcW = ((ColW > 16) ? ColW : 16) + 1;

  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;

  logic [CalcW-1:0] wd, ht, row_len, col_eff, row_eff, col_nxt, row_nxt;
  logic [CalcW-1:0] top_h, left_w, row_lo, row_hi, col_lo, col_hi;
  logic             h_err, w_err, in_win, row_end, last_row, err;
  logic [PadW-1:0]  pad;

  // Clamp source size and derive stored row length (3 bytes per pixel plus pad)
  always_comb begin
    if (cfg_i.src_width == '0) begin
      wd = CalcW'(1);
    end else if (CalcW'(cfg_i.src_width) > CalcW'(MAX_WIDTH)) begin
      wd = CalcW'(MAX_WIDTH);
    end else begin
      wd = CalcW'(cfg_i.src_width);
    end
    if (cfg_i.src_height == '0) begin
      ht = CalcW'(1);
    end else if (CalcW'(cfg_i.src_height) > CalcW'(MAX_HEIGHT)) begin
      ht = CalcW'(MAX_HEIGHT);
    end else begin
      ht = CalcW'(cfg_i.src_height);
    end
    row_len = (wd << 1) + wd + {{(CalcW-2){1'b0}}, wd[1:0]};
  end

  // Window bounds and checks
  always_comb begin
    col_eff  = (CalcW'(col_q) >= row_len) ? '0 : CalcW'(col_q);
    row_eff  = (CalcW'(row_q) >= ht) ? '0 : CalcW'(row_q);
    top_h    = CalcW'(cfg_i.crop_top) + CalcW'(cfg_i.crop_height);
    left_w   = CalcW'(cfg_i.crop_left) + CalcW'(cfg_i.crop_width);
    h_err    = top_h > ht;
    w_err    = !h_err && (left_w > wd);
    err      = h_err || w_err;
    row_lo   = ht - top_h;
    row_hi   = ht - CalcW'(cfg_i.crop_top);
    col_lo   = (CalcW'(cfg_i.crop_left) << 1) + CalcW'(cfg_i.crop_left);
    col_hi   = (left_w << 1) + left_w;
    in_win   = (cfg_i.crop_width != '0) && (cfg_i.crop_height != '0) &&
               (row_eff >= row_lo) && (row_eff < row_hi) &&
               (col_eff >= col_lo) && (col_eff < col_hi);
    row_end  = col_eff == (col_hi - CalcW'(1));
    last_row = row_eff == (row_hi - CalcW'(1));
    // Pad of a cropped row: (3*w) padded to four bytes gives w mod 4 zeros
    pad      = row_end ? cfg_i.crop_width[PadW-1:0] : '0;
  end

  // Build the work description
  always_comb begin
    keep_o = err || in_win;
    if (h_err) begin
      desc_o = '{data: '0, status: ST_HEIGHT_ERR, pad: '0, last_row: 1'b0,
                 img_last: 1'b0};
    end else if (w_err) begin
      desc_o = '{data: '0, status: ST_WIDTH_ERR, pad: '0, last_row: 1'b0,
                 img_last: 1'b0};
    end else begin
      desc_o = '{data: pixel_byte_i, status: ST_OK, pad: pad, last_row: last_row,
                 img_last: row_end && last_row && (pad == '0)};
    end
  end

  // Advance the byte column, wrap into the next stored row and image
  always_comb begin
    col_nxt = col_eff + CalcW'(1);
    row_nxt = row_eff + CalcW'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (advance_i) begin
      if (col_nxt >= row_len) begin
        col_d = '0;
        row_d = (row_nxt >= ht) ? '0 : row_nxt[RowW-1:0];
      end else begin
        col_d = col_nxt[ColW-1:0];
        row_d = row_eff[RowW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

@@ rtl/bmp_crop_stream.sv @@
// Top level: streaming crop of a 24-bit bottom-up BMP pixel array.
//
// Takes one source byte per cycle, padding included, and passes on the bytes of
// the crop window, appending zero bytes so each cropped row is a multiple of
// four. An input register holds the work of the latest byte and a result
// register drives the output, so a new byte is taken every cycle while results
// flow. A byte closing a cropped row yields 1 to 4 results, holding the result
// register until all are taken (pad countdown); other bytes yield one or none.
// Bounds errors give one status result per byte. Users must write configuration
// through the plain write port while idle; the block does not enforce it.
module bmp_crop_stream
  import bmpc_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RegIdxW-1:0]  cfg_index_i,
  input  logic [RegW-1:0]     cfg_wdata_i,
  bmpc_in_if.sink             in_i,
  bmpc_out_if.source          out_o
);

  cfg_t            cfg_q, cfg_d;
  logic            keep;
  desc_t           desc_new;
  desc_t           desc_q;
  logic            desc_vld_q, desc_vld_d;
  logic            in_fire, desc_move, out_done;

  logic [ByteW-1:0] obyte_q, obyte_d;
  status_e          ostat_q, ostat_d;
  logic             oeor_q, oeor_d;
  logic             olast_q, olast_d;
  logic             ovld_q, ovld_d;
  logic [PadW-1:0]  orem_q, orem_d;
  logic             orow_q, orow_d;

  // Configuration register writes; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_SRC_WIDTH:   cfg_d.src_width   = cfg_wdata_i;
        REG_SRC_HEIGHT:  cfg_d.src_height  = cfg_wdata_i;
        REG_CROP_LEFT:   cfg_d.crop_left   = cfg_wdata_i;
        REG_CROP_TOP:    cfg_d.crop_top    = cfg_wdata_i;
        REG_CROP_WIDTH:  cfg_d.crop_width  = cfg_wdata_i;
        REG_CROP_HEIGHT: cfg_d.crop_height = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{src_width: RegW'(1), src_height: RegW'(1), default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Position tracking and window decision
  bmpc_track #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (in_fire),
    .pixel_byte_i (in_i.pixel_byte),
    .cfg_i        (cfg_q),
    .keep_o       (keep),
    .desc_o       (desc_new)
  );

  // Handshake: the result register finishes its transaction when no pad is left
  assign out_done  = ovld_q && out_o.ready && (orem_q == '0);
  assign desc_move = desc_vld_q && (!ovld_q || out_done);
  assign in_i.ready = !desc_vld_q || desc_move;
  assign in_fire   = in_i.valid && in_i.ready;

  // Input register: hold the work of one accepted byte; drop bytes with no result
  always_comb begin
    desc_vld_d = desc_vld_q;
    if (desc_move) begin
      desc_vld_d = 1'b0;
    end
    if (in_fire) begin
      desc_vld_d = keep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_vld_q <= 1'b0;
    end else begin
      desc_vld_q <= desc_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      desc_q <= desc_new;
    end
  end

  // Result register: load a new item or count down appended pad bytes
  always_comb begin
    ovld_d  = ovld_q;
    obyte_d = obyte_q;
    ostat_d = ostat_q;
    oeor_d  = oeor_q;
    olast_d = olast_q;
    orem_d  = orem_q;
    orow_d  = orow_q;
    if (desc_move) begin
      ovld_d  = 1'b1;
      obyte_d = desc_q.data;
      ostat_d = desc_q.status;
      oeor_d  = desc_q.pad == '0;
      olast_d = desc_q.img_last;
      orem_d  = desc_q.pad;
      orow_d  = desc_q.last_row;
    end else if (out_done) begin
      ovld_d = 1'b0;
    end else if (ovld_q && out_o.ready) begin
      obyte_d = '0;
      ostat_d = ST_OK;
      oeor_d  = orem_q == PadW'(1);
      olast_d = (orem_q == PadW'(1)) && orow_q;
      orem_d  = orem_q - PadW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
      orem_q <= '0;
    end else begin
      ovld_q <= ovld_d;
      orem_q <= orem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    ostat_q <= ostat_d;
    oeor_q  <= oeor_d;
    olast_q <= olast_d;
    orow_q  <= orow_d;
  end

  // Drive the result channel
  assign out_o.valid         = ovld_q;
  assign out_o.out_byte      = obyte_q;
  assign out_o.status        = ostat_q;
  assign out_o.end_of_run    = oeor_q;
  assign out_o.last_of_image = olast_q;

endmodule

@@ dv/crop_checker.sv @@
`timescale 1ns / 1ps
// Checker: mirrors the crop configuration, predicts the output bytes and compares them.
module crop_checker
  import bmpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [RegIdxW-1:0] cfg_index_i,
  input  logic [RegW-1:0]    cfg_wdata_i,
  bmpc_in_if                 in_i,
  bmpc_out_if                out_i,
  output int unsigned        err_cnt_o,
  output int unsigned        pending_o
);

  typedef struct packed {
    logic [ByteW-1:0] data;
    status_e          status;
    logic             run_end;
    logic             img_end;
  } crop_byte_t;

  // Expected output bytes, oldest first
  crop_byte_t crop_q[$];
  crop_byte_t want;

  // Shadow copy of the configuration registers
  logic [RegW-1:0] src_w, src_h, left_px, top_row, win_w, win_h;

  // Byte column within the stored row and stored row, bottom row first
  int unsigned col_pos, row_pos;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic int unsigned pad_bytes(int unsigned pixels);
    return (4 - ((pixels * 3) & 3)) & 3;
  endfunction

  function automatic crop_byte_t pack_byte(logic [ByteW-1:0] data, status_e st,
                                           logic run_end, logic img_end);
    crop_byte_t r;
    r.data    = data;
    r.status  = st;
    r.run_end = run_end;
    r.img_end = img_end;
    return r;
  endfunction

  // Queue the output bytes caused by one source byte and advance the position
  task automatic crop_step(input logic [ByteW-1:0] b);
    int unsigned wd, ht, row_len, col, row;
    int unsigned l, t, w, h;
    int unsigned row_lo, row_hi, col_lo, col_hi, npad, k;
    logic row_end, last_row;
    wd      = clamp_dim(32'(src_w), MaxWidthDef);
    ht      = clamp_dim(32'(src_h), MaxHeightDef);
    row_len = wd * 3 + pad_bytes(wd);
    l       = 32'(left_px);
    t       = 32'(top_row);
    w       = 32'(win_w);
    h       = 32'(win_h);
    col     = col_pos;
    row     = row_pos;
    if (col >= row_len) col = 0;
    if (row >= ht) row = 0;

    if (t + h > ht) begin
      crop_q.push_back(pack_byte(8'h00, ST_HEIGHT_ERR, 1'b1, 1'b0));
    end else if (l + w > wd) begin
      crop_q.push_back(pack_byte(8'h00, ST_WIDTH_ERR, 1'b1, 1'b0));
    end else if (w != 0 && h != 0) begin
      row_lo = ht - (t + h);
      row_hi = ht - t;
      col_lo = l * 3;
      col_hi = (l + w) * 3;
      if (row >= row_lo && row < row_hi && col >= col_lo && col < col_hi) begin
        row_end  = (col == col_hi - 1);
        last_row = (row == row_hi - 1);
        npad     = row_end ? pad_bytes(w) : 0;
        crop_q.push_back(pack_byte(b, ST_OK, npad == 0, row_end && last_row && npad == 0));
        // append zero padding after the last kept byte of a row
        for (k = 1; k <= npad; k++) begin
          crop_q.push_back(pack_byte(8'h00, ST_OK, k == npad, k == npad && last_row));
        end
      end
    end

    col++;
    if (col >= row_len) begin
      col = 0;
      row++;
      if (row >= ht) row = 0;
    end
    col_pos = col;
    row_pos = row;
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_val,
                             input logic [7:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      err_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w   = 13'd1;
      src_h   = 13'd1;
      left_px = '0;
      top_row = '0;
      win_w   = '0;
      win_h   = '0;
      col_pos = 0;
      row_pos = 0;
      crop_q.delete();
    end else begin
      // compare an accepted output transaction with the oldest expectation
      if (out_i.valid && out_i.ready) begin
        if (crop_q.size() == 0) begin
          $error("out_byte: expected none, actual %0d (status %0d)",
                 out_i.out_byte, out_i.status);
          err_cnt_o++;
        end else begin
          want = crop_q.pop_front();
          check_field("out_byte", want.data, out_i.out_byte);
          check_field("status", 8'(want.status), 8'(out_i.status));
          check_field("end_of_run", 8'(want.run_end), 8'(out_i.end_of_run));
          check_field("last_of_image", 8'(want.img_end), 8'(out_i.last_of_image));
        end
      end

      // predict on an accepted input transaction
      if (in_i.valid && in_i.ready) crop_step(in_i.pixel_byte);

      // track register writes; other indexes are ignored
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SRC_WIDTH:   src_w   = cfg_wdata_i;
          REG_SRC_HEIGHT:  src_h   = cfg_wdata_i;
          REG_CROP_LEFT:   left_px = cfg_wdata_i;
          REG_CROP_TOP:    top_row = cfg_wdata_i;
          REG_CROP_WIDTH:  win_w   = cfg_wdata_i;
          REG_CROP_HEIGHT: win_h   = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    pending_o = crop_q.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top: drives bytes and register writes into the crop stream and gives the verdict.
module tb_top
  import bmpc_pkg::*;
();

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned RandomBytes = 410;
  localparam logic [RegIdxW-1:0] RegIdxSpareLo = 3'd6;
  localparam logic [RegIdxW-1:0] RegIdxSpareHi = 3'd7;
  localparam logic [RegW-1:0]    RegAllOnes    = 13'h1FFF;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [RegIdxW-1:0] cfg_index_i;
  logic [RegW-1:0]    cfg_wdata_i;

  logic        quiet;
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt, exp_pending;
  int unsigned rand_sent, stall, nbytes, kind, i;
  int unsigned sw, sh, cl, ct, cw, ch;

  bmpc_in_if  in_if ();
  bmpc_out_if out_if ();

  bmp_crop_stream DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  crop_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_i       (out_if),
    .err_cnt_o   (err_cnt),
    .pending_o   (exp_pending)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Stall the result side for a random number of cycles before each transaction
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      stall = quiet ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
    end
  end

  // Hold a register write for one cycle; the caller drops the enable
  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [RegW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [RegW-1:0] w, input logic [RegW-1:0] h,
                           input logic [RegW-1:0] l, input logic [RegW-1:0] t,
                           input logic [RegW-1:0] cwid, input logic [RegW-1:0] chgt);
    write_reg(REG_SRC_WIDTH, w);
    write_reg(REG_SRC_HEIGHT, h);
    write_reg(REG_CROP_LEFT, l);
    write_reg(REG_CROP_TOP, t);
    write_reg(REG_CROP_WIDTH, cwid);
    write_reg(REG_CROP_HEIGHT, chgt);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one source byte after a random gap and wait for its transaction
  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.pixel_byte <= b;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every expected result, then let the pipeline empty
  task automatic drain();
    in_if.valid <= 1'b0;
    while (exp_pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = REG_SRC_WIDTH;
    cfg_wdata_i      = '0;
    in_if.valid      = 1'b0;
    in_if.pixel_byte = '0;
    quiet            = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty window under reset values
    push_byte(8'h00);
    push_byte(8'hFF);
    drain();

    // one-pixel image kept whole, one pad byte per row
    configure(13'd1, 13'd1, 13'd0, 13'd0, 13'd1, 13'd1);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'hA5);
    push_byte(8'h5A);
    drain();

    // window taller than the image
    write_reg(REG_CROP_HEIGHT, 13'd2);
    cfg_we_i <= 1'b0;
    push_byte(8'h3C);
    push_byte(8'hC3);
    drain();

    // window wider than the image
    write_reg(REG_CROP_HEIGHT, 13'd1);
    write_reg(REG_CROP_LEFT, 13'd1);
    cfg_we_i <= 1'b0;
    push_byte(8'h81);
    push_byte(8'h7E);
    drain();

    // zero width acts as one, oversize height clamps to the maximum
    quiet = 1'b1;
    configure(13'd0, RegAllOnes, 13'd0, 13'd4095, 13'd1, 13'd1);
    push_byte(8'h01);
    push_byte(8'h80);
    push_byte(8'h55);
    push_byte(8'hAA);
    drain();

    // widest image, window at the far right edge, writes to unused indexes
    quiet = 1'b0;
    write_reg(RegIdxSpareLo, RegAllOnes);
    write_reg(RegIdxSpareHi, RegAllOnes);
    configure(RegAllOnes, 13'd2, 13'd4095, 13'd0, 13'd1, 13'd1);
    push_byte(8'hF0);
    push_byte(8'h0F);
    push_byte(8'hFF);
    drain();

    // random phases: mostly valid windows on small images
    rand_sent = 0;
    while (rand_sent < RandomBytes) begin
      quiet = ($urandom_range(0, 3) == 0);
      kind  = $urandom_range(0, 9);
      sw = $urandom_range(1, 8);
      sh = $urandom_range(1, 5);
      cl = $urandom_range(0, sw - 1);
      cw = $urandom_range(1, sw - cl);
      ct = $urandom_range(0, sh - 1);
      ch = $urandom_range(1, sh - ct);
      nbytes = ((3 * sw + 3) / 4) * 4 * sh * $urandom_range(1, 2);
      if (nbytes > 64) nbytes = 64;
      case (kind)
        0: begin
          // height out of bounds
          ch = sh - ct + $urandom_range(1, 3);
          nbytes = $urandom_range(4, 16);
        end
        1: begin
          // width out of bounds
          cw = sw - cl + $urandom_range(1, 3);
          nbytes = $urandom_range(4, 16);
        end
        2: begin
          // empty window
          if ($urandom_range(0, 1) != 0) cw = 0;
          else ch = 0;
          nbytes = $urandom_range(4, 16);
        end
        3: begin
          // zero source size acts as one
          if ($urandom_range(0, 1) != 0) begin
            sw = 0;
            cl = 0;
            cw = 1;
          end else begin
            sh = 0;
            ct = 0;
            ch = 1;
          end
        end
        4: begin
          // full register range
          sw = $urandom_range(0, RegAllOnes);
          sh = $urandom_range(0, RegAllOnes);
          cl = $urandom_range(0, RegAllOnes);
          ct = $urandom_range(0, RegAllOnes);
          cw = $urandom_range(0, RegAllOnes);
          ch = $urandom_range(0, RegAllOnes);
          nbytes = $urandom_range(4, 16);
        end
        default: ;
      endcase
      configure(RegW'(sw), RegW'(sh), RegW'(cl), RegW'(ct), RegW'(cw), RegW'(ch));
      for (i = 0; i < nbytes; i++) begin
        push_byte(8'($urandom_range(0, 255)));
        rand_sent++;
      end
      drain();
    end

    if (err_cnt == 0 && exp_pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ bmp_crop_stream.f @@
rtl/bmpc_pkg.sv
rtl/bmpc_in_if.sv
rtl/bmpc_out_if.sv
rtl/bmpc_track.sv
rtl/bmp_crop_stream.sv
dv/crop_checker.sv
dv/tb_top.sv
